### hdl/cbm_pkg.sv
// ============================================================================
// cbm_pkg: shared types and constants for the cartridge bank mapper
// Bus target codes, address map constants and the result record.
// ============================================================================
`default_nettype none

package cbm_pkg;

    // Default and full width of the ROM bank register
    localparam int ROM_BANK_BITS_DEFAULT = 7;
    localparam int ROM_BANK_FULL_BITS    = 7;

    // Field widths
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 21;
    localparam int RAM_ADDR_W = 15;
    localparam int RAM_BANK_W = 2;
    localparam int TYPE_W     = 8;

    // Address offset bits inside a ROM bank (16 KiB) and a RAM bank (8 KiB)
    localparam int ROM_OFS_W = 14;
    localparam int RAM_OFS_W = 13;

    // Interrupt register addresses
    localparam logic [ADDR_W-1:0] IRQ_FLAG_ADDR   = 16'hFF0F;
    localparam logic [ADDR_W-1:0] IRQ_ENABLE_ADDR = 16'hFFFF;

    // RAM enable key in the low nibble
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    // Lower bank field width; a zero written to this field is replaced by one
    localparam int BANK_LOW_W = 5;

    // Bus targets
    typedef enum logic [2:0] {
        TGT_ROM   = 3'd0,
        TGT_RAM   = 3'd1,
        TGT_LOCAL = 3'd2,
        TGT_IRQ   = 3'd3,
        TGT_NONE  = 3'd4
    } target_t;

    // One result transaction
    typedef struct packed {
        target_t                 target;
        logic [ROM_ADDR_W-1:0]   rom_address;
        logic [RAM_ADDR_W-1:0]   ram_address;
        logic [ADDR_W-1:0]       local_address;
        logic                    ram_enable_flag;
    } result_t;

endpackage

`default_nettype wire

### hdl/cartridge_bank_mapper.sv
// ============================================================================
// cartridge_bank_mapper
// MBC1-style bank controller: routes CPU bus accesses and translates addresses.
// ============================================================================
// One bus access per cycle goes in while in_stall is low, and one result per
// access comes out. The decode is a single pass of logic from the accepted access
// and the bank registers into the result register; a skid register behind it lets
// the input keep flowing for one more transaction while the output is stalled, so
// in_stall is a registered signal. Reads are routed to cartridge ROM
// (0x4000-0x7FFF through the switchable bank), external RAM (0xA000-0xBFFF through
// the RAM bank, when a mapper is present), the interrupt registers or internal
// memory. Writes below 0x8000 program the bank registers when the cartridge type
// byte is 1 to 3. ram_enable_flag shows the RAM enable state after the
// transaction; RAM reads are routed regardless. The user must write the type byte
// through the cfg port only while the block is idle; the block does not check it.
`default_nettype none

module cartridge_bank_mapper
    import cbm_pkg::*;
#(
    parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [TYPE_W-1:0]     cart_type_byte,

    // Bus access input
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  req_type,
    input  wire logic [ADDR_W-1:0]     address,
    input  wire logic [DATA_W-1:0]     write_data,

    // Result output
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [2:0]                 target,
    output logic [ROM_ADDR_W-1:0]      rom_address,
    output logic [RAM_ADDR_W-1:0]      ram_address,
    output logic [ADDR_W-1:0]          local_address,
    output logic                       ram_enable_flag
);

    // Mapper state
    logic [TYPE_W-1:0]        cart_type_reg;
    logic [ROM_BANK_BITS-1:0] rom_bank_reg, rom_bank_next;
    logic [RAM_BANK_W-1:0]    ram_bank_reg, ram_bank_next;
    logic                     ram_enabled_reg, ram_enabled_next;
    logic                     bank_mode_reg, bank_mode_next;

    // Output and skid stages
    result_t out_data_reg, skid_data_reg;
    logic    out_valid_reg, skid_valid_reg;

    // Decode signals
    logic                          in_acc;
    logic                          out_take;
    logic                          no_mapper;
    logic                          is_mbc1;
    logic                          irq_hit;
    logic [ROM_BANK_FULL_BITS-1:0] bank_ext;
    logic [ROM_BANK_FULL_BITS-1:0] bank_low_upd;
    logic [ROM_BANK_FULL_BITS-1:0] bank_high_upd;
    logic [BANK_LOW_W-1:0]         low_field;
    result_t                       res;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign no_mapper = (cart_type_reg == '0);
    assign is_mbc1   = (cart_type_reg[TYPE_W-1:2] == '0) && (cart_type_reg[1:0] != 2'b00);
    assign irq_hit   = (address == IRQ_FLAG_ADDR) || (address == IRQ_ENABLE_ADDR);

    // Candidate bank values for the two bank-number write windows
    assign bank_ext      = ROM_BANK_FULL_BITS'(rom_bank_reg);
    assign low_field     = (write_data[BANK_LOW_W-1:0] == '0) ?
                           BANK_LOW_W'(1) : write_data[BANK_LOW_W-1:0];
    assign bank_low_upd  = {bank_ext[ROM_BANK_FULL_BITS-1:BANK_LOW_W], low_field};
    assign bank_high_upd = {write_data[1:0], bank_ext[BANK_LOW_W-1:0]};

    // Register writes from the bus
    always_comb
    begin
        rom_bank_next    = rom_bank_reg;
        ram_bank_next    = ram_bank_reg;
        ram_enabled_next = ram_enabled_reg;
        bank_mode_next   = bank_mode_reg;
        if (in_acc && req_type && !address[ADDR_W-1] && is_mbc1)
        begin
            unique case (address[14:13])
                2'b00:
                begin
                    ram_enabled_next = (write_data[3:0] == RAM_ENABLE_KEY);
                end
                2'b01:
                begin
                    rom_bank_next = bank_low_upd[ROM_BANK_BITS-1:0];
                end
                2'b10:
                begin
                    if (bank_mode_reg)
                        ram_bank_next = write_data[RAM_BANK_W-1:0];
                    else
                        rom_bank_next = bank_high_upd[ROM_BANK_BITS-1:0];
                end
                2'b11:
                begin
                    bank_mode_next = write_data[0];
                end
                default:
                begin
                    bank_mode_next = bank_mode_reg;
                end
            endcase
        end
    end

    // Routing and address translation
    always_comb
    begin
        res                 = '0;
        res.target          = TGT_NONE;
        res.ram_enable_flag = ram_enabled_next;
        if (req_type)
        begin
            if (address[ADDR_W-1] && irq_hit)
            begin
                res.target        = TGT_IRQ;
                res.local_address = address;
            end
        end
        else
        begin
            priority if (address[15:14] == 2'b00)
            begin
                res.target      = TGT_ROM;
                res.rom_address = ROM_ADDR_W'(address);
            end
            else if (address[15:14] == 2'b01)
            begin
                res.target = TGT_ROM;
                if (no_mapper)
                    res.rom_address = ROM_ADDR_W'(address);
                else
                    res.rom_address = {bank_ext, address[ROM_OFS_W-1:0]};
            end
            else if ((address[15:13] == 3'b101) && !no_mapper)
            begin
                res.target      = TGT_RAM;
                res.ram_address = {ram_bank_reg, address[RAM_OFS_W-1:0]};
            end
            else if (irq_hit)
            begin
                res.target        = TGT_IRQ;
                res.local_address = address;
            end
            else
            begin
                res.target        = TGT_LOCAL;
                res.local_address = address;
            end
        end
    end

    // Config and bank registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_type_reg   <= '0;
            rom_bank_reg    <= ROM_BANK_BITS'(1);
            ram_bank_reg    <= '0;
            ram_enabled_reg <= 1'b0;
            bank_mode_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cart_type_reg <= cart_type_byte;
            rom_bank_reg    <= rom_bank_next;
            ram_bank_reg    <= ram_bank_next;
            ram_enabled_reg <= ram_enabled_next;
            bank_mode_reg   <= bank_mode_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_acc;
                end
            end
            else if (in_acc)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload of the output and skid stages
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_acc)
                out_data_reg <= res;
        end
        else if (in_acc)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign target          = out_data_reg.target;
    assign rom_address     = out_data_reg.rom_address;
    assign ram_address     = out_data_reg.ram_address;
    assign local_address   = out_data_reg.local_address;
    assign ram_enable_flag = out_data_reg.ram_enable_flag;

endmodule

`default_nettype wire
